// File: src/clw_pkg.sv
// Shared types, codes and constants of the character display nibble writer.
`default_nettype none
package clw_pkg;

  localparam int CFG_W      = 16;
  localparam int NUM_BITS   = 32;
  localparam int BCD_DIGITS = 10;
  localparam int ITEM_W     = $clog2(BCD_DIGITS + 1);
  localparam int STEP_W     = $clog2(NUM_BITS);

  localparam int DEF_MAX_DIGITS = 10;

  // Request kinds.
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CMD    = 3'd1;
  localparam logic [2:0] REQ_DATA   = 3'd2;
  localparam logic [2:0] REQ_NUMBER = 3'd3;
  localparam logic [2:0] REQ_CURSOR = 3'd4;
  localparam logic [2:0] REQ_SHIFT  = 3'd5;
  localparam logic [2:0] REQ_CLEAR  = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PULSE    = 2'd0;
  localparam logic [1:0] CFG_SETTLE   = 2'd1;
  localparam logic [1:0] CFG_CLEAR    = 2'd2;
  localparam logic [1:0] CFG_POWER_UP = 2'd3;

  localparam logic [CFG_W-1:0] RST_PULSE    = 16'd1000;
  localparam logic [CFG_W-1:0] RST_SETTLE   = 16'd45;
  localparam logic [CFG_W-1:0] RST_CLEAR    = 16'd2000;
  localparam logic [CFG_W-1:0] RST_POWER_UP = 16'd40000;

  // Display command bytes.
  localparam logic [7:0] CMD_INIT_NIBBLE = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0F;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] LINE0_BASE      = 8'h80;
  localparam logic [7:0] LINE1_BASE      = 8'hC0;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;

  // Items of the init sequence.
  localparam logic [ITEM_W-1:0] INIT_ITEM_NIBBLE = 4'd0;
  localparam logic [ITEM_W-1:0] INIT_ITEM_FUNC   = 4'd1;
  localparam logic [ITEM_W-1:0] INIT_ITEM_DISP   = 4'd2;
  localparam logic [ITEM_W-1:0] INIT_ITEM_CLEAR  = 4'd3;
  localparam logic [ITEM_W-1:0] INIT_ITEM_LAST   = 4'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  byte_value;
    logic [31:0] number_value;
    logic        line_select;
    logic [5:0]  cursor_column;
    logic        shift_right;
  } req_t;

  typedef struct packed {
    logic             reg_select;
    logic [3:0]       bus_nibble;
    logic [CFG_W-1:0] wait_before_us;
    logic [CFG_W-1:0] pulse_us;
    logic [CFG_W-1:0] wait_after_us;
    logic             last_transfer;
  } xfer_t;

  typedef struct packed {
    logic              load_req;
    logic              conv_start;
    logic              conv_step;
    logic              count_digits;
    logic              emit;
    logic              half;
    logic [ITEM_W-1:0] item_idx;
    logic              last;
  } ctl_cmd_t;

  typedef struct packed {
    logic              out_free;
    logic [ITEM_W-1:0] digit_cnt;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/clw_ctrl.sv
// Controller state machine that walks a request through conversion and transfers.
`default_nettype none
module clw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [2:0]          in_req_type,
  output logic                     in_stall,
  input  wire clw_pkg::dp_status_t status,
  output clw_pkg::ctl_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_SEND
  } state_t;

  state_t                          state_r, state_nxt;
  logic [2:0]                      kind_r, kind_nxt;
  logic                            half_r, half_nxt;
  logic [clw_pkg::ITEM_W-1:0]      item_r, item_nxt;
  logic [clw_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [clw_pkg::ITEM_W-1:0]      last_item;

  always_comb begin
    case (kind_r)
      clw_pkg::REQ_INIT:   last_item = clw_pkg::INIT_ITEM_LAST;
      clw_pkg::REQ_NUMBER: last_item = status.digit_cnt - clw_pkg::ITEM_W'(1);
      default:             last_item = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    half_nxt  = half_r;
    item_nxt  = item_r;
    step_nxt  = step_r;
    in_stall  = (state_r != ST_IDLE);
    cmd       = '0;
    cmd.half     = half_r;
    cmd.item_idx = item_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          kind_nxt     = in_req_type;
          item_nxt     = '0;
          // The init sequence opens with a lone low nibble.
          half_nxt     = (in_req_type == clw_pkg::REQ_INIT);
          if (in_req_type == clw_pkg::REQ_NUMBER) begin
            cmd.conv_start = 1'b1;
            step_nxt       = '0;
            state_nxt      = ST_CONVERT;
          end else if (in_req_type inside {[clw_pkg::REQ_INIT:clw_pkg::REQ_CLEAR]}) begin
            state_nxt = ST_SEND;
          end
        end
      end
      ST_CONVERT: begin
        cmd.conv_step = 1'b1;
        step_nxt      = step_r + clw_pkg::STEP_W'(1);
        if (step_r == clw_pkg::STEP_W'(clw_pkg::NUM_BITS - 1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count_digits = 1'b1;
        state_nxt        = ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = half_r && (item_r == last_item);
          if (!half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            item_nxt = item_r + clw_pkg::ITEM_W'(1);
          end
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= '0;
      half_r  <= 1'b0;
      item_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      half_r  <= half_nxt;
      item_r  <= item_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/clw_datapath.sv
// Datapath: configuration registers, binary to decimal converter and output word register.
`default_nettype none
module clw_datapath #(
  parameter int MAX_DIGITS = clw_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [clw_pkg::CFG_W-1:0] cfg_data,
  input  wire clw_pkg::req_t             in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output clw_pkg::xfer_t                 out_data,
  input  wire clw_pkg::ctl_cmd_t         cmd,
  output clw_pkg::dp_status_t            status
);

  localparam int ITEM_W = clw_pkg::ITEM_W;

  logic [clw_pkg::CFG_W-1:0] pulse_r, settle_r, clear_r, power_up_r;
  clw_pkg::req_t             req_r;
  logic [clw_pkg::NUM_BITS-1:0] bin_r;
  logic [3:0]                bcd_r [clw_pkg::BCD_DIGITS];
  logic [3:0]                bcd_nxt [clw_pkg::BCD_DIGITS];
  logic [3:0]                bcd_adj [clw_pkg::BCD_DIGITS];
  logic [ITEM_W-1:0]         digit_cnt_r, digit_cnt_nxt;
  logic [ITEM_W-1:0]         ndig;
  logic [ITEM_W-1:0]         digit_idx;
  logic [3:0]                digit;
  logic                      out_valid_r;
  clw_pkg::xfer_t            out_data_r, xfer_nxt;
  logic [7:0]                byte_sel;
  logic                      rs_sel;
  logic [clw_pkg::CFG_W-1:0] after_sel, before_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r    <= clw_pkg::RST_PULSE;
      settle_r   <= clw_pkg::RST_SETTLE;
      clear_r    <= clw_pkg::RST_CLEAR;
      power_up_r <= clw_pkg::RST_POWER_UP;
    end else if (cfg_we) begin
      case (cfg_index)
        clw_pkg::CFG_PULSE:    pulse_r    <= cfg_data;
        clw_pkg::CFG_SETTLE:   settle_r   <= cfg_data;
        clw_pkg::CFG_CLEAR:    clear_r    <= cfg_data;
        clw_pkg::CFG_POWER_UP: power_up_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
  end

  // Shift-and-add-3 conversion, one input bit per cycle.
  always_comb begin
    for (int i = 0; i < clw_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_nxt[0] = {bcd_adj[0][2:0], bin_r[clw_pkg::NUM_BITS-1]};
    for (int i = 1; i < clw_pkg::BCD_DIGITS; i++) begin
      bcd_nxt[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      bin_r <= in_data.number_value;
      for (int i = 0; i < clw_pkg::BCD_DIGITS; i++) begin
        bcd_r[i] <= '0;
      end
    end else if (cmd.conv_step) begin
      bin_r <= {bin_r[clw_pkg::NUM_BITS-2:0], 1'b0};
      for (int i = 0; i < clw_pkg::BCD_DIGITS; i++) begin
        bcd_r[i] <= bcd_nxt[i];
      end
    end
  end

  // Number of significant digits, at least one, then held to the digit limit.
  always_comb begin
    ndig = ITEM_W'(1);
    for (int i = 1; i < clw_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        ndig = ITEM_W'(i + 1);
      end
    end
    digit_cnt_nxt = (int'(ndig) > MAX_DIGITS) ? ITEM_W'(MAX_DIGITS) : ndig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_cnt_r <= ITEM_W'(1);
    end else if (cmd.count_digits) begin
      digit_cnt_r <= digit_cnt_nxt;
    end
  end

  // Digits go out most significant first among those kept.
  always_comb begin
    digit_idx = digit_cnt_r - ITEM_W'(1) - cmd.item_idx;
    digit     = '0;
    for (int i = 0; i < clw_pkg::BCD_DIGITS; i++) begin
      if (digit_idx == ITEM_W'(i)) begin
        digit = bcd_r[i];
      end
    end
  end

  always_comb begin
    byte_sel   = '0;
    rs_sel     = 1'b0;
    after_sel  = '0;
    before_sel = '0;
    case (req_r.req_type)
      clw_pkg::REQ_INIT: begin
        case (cmd.item_idx)
          clw_pkg::INIT_ITEM_NIBBLE: begin
            byte_sel   = clw_pkg::CMD_INIT_NIBBLE;
            before_sel = power_up_r;
          end
          clw_pkg::INIT_ITEM_FUNC: begin
            byte_sel  = clw_pkg::CMD_FUNC_SET;
            after_sel = settle_r;
          end
          clw_pkg::INIT_ITEM_DISP: begin
            byte_sel  = clw_pkg::CMD_DISPLAY_ON;
            after_sel = settle_r;
          end
          clw_pkg::INIT_ITEM_CLEAR: begin
            byte_sel  = clw_pkg::CMD_CLEAR;
            after_sel = clear_r;
          end
          default: begin
            byte_sel = clw_pkg::CMD_ENTRY_MODE;
          end
        endcase
      end
      clw_pkg::REQ_CMD: begin
        byte_sel = req_r.byte_value;
      end
      clw_pkg::REQ_DATA: begin
        byte_sel = req_r.byte_value;
        rs_sel   = 1'b1;
      end
      clw_pkg::REQ_NUMBER: begin
        byte_sel = clw_pkg::ASCII_ZERO + {4'd0, digit};
        rs_sel   = 1'b1;
      end
      clw_pkg::REQ_CURSOR: begin
        byte_sel  = (req_r.line_select ? clw_pkg::LINE1_BASE : clw_pkg::LINE0_BASE)
                    + {2'd0, req_r.cursor_column};
        after_sel = settle_r;
      end
      clw_pkg::REQ_SHIFT: begin
        byte_sel  = req_r.shift_right ? clw_pkg::CMD_SHIFT_RIGHT : clw_pkg::CMD_SHIFT_LEFT;
        after_sel = settle_r;
      end
      clw_pkg::REQ_CLEAR: begin
        byte_sel  = clw_pkg::CMD_CLEAR;
        after_sel = clear_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    xfer_nxt.reg_select     = rs_sel;
    xfer_nxt.bus_nibble     = cmd.half ? byte_sel[3:0] : byte_sel[7:4];
    xfer_nxt.wait_before_us = before_sel;
    xfer_nxt.pulse_us       = pulse_r;
    xfer_nxt.wait_after_us  = cmd.half ? after_sel : '0;
    xfer_nxt.last_transfer  = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= xfer_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.digit_cnt = digit_cnt_r;

endmodule
`default_nettype wire

// File: src/char_lcd_4bit_writer.sv
// Top level of the 4-bit character display writer.
//
// Usage: a request word enters on in_valid/in_stall/in_data (req_t) and turns
// into a run of nibble transfer words on out_valid/out_stall/out_data (xfer_t),
// high nibble before low nibble, the final word marked by last_transfer.
// Configuration registers are written through cfg_we/cfg_index/cfg_data, one
// per cycle. The user must write them only while no request is in flight; the
// block does not enforce it. Timing: once a request is accepted, each of its
// transfer words is registered into the output register by the send state
// whenever that register is free. A number request first runs the converter
// over all 32 input bits (one input bit per cycle) and then a digit count step
// before its first word goes out. After that one word leaves per cycle without
// stall: 2 words per byte, 9 for init, up to 20 for a number. in_stall stays
// high while a request is worked on and drops once its last word sits in the
// output register, so the next request can be taken while that word waits.
// When the receiver stalls, the output word holds and the sequence pauses.
// A reset restores the register defaults and empties the output register.
`default_nettype none
module char_lcd_4bit_writer #(
  parameter int MAX_DIGITS = clw_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire clw_pkg::req_t             in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output clw_pkg::xfer_t                 out_data,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [clw_pkg::CFG_W-1:0] cfg_data
);

  clw_pkg::ctl_cmd_t   cmd;
  clw_pkg::dp_status_t status;

  clw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  clw_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire
